// File: design/ofs_pkg.sv
// ----------------------------------------------------------------------------
// Octupole field strength package
// Shared widths, pipeline depths, register indexes and constants for the
// octupole field strength unit and its divider pipeline.
// ----------------------------------------------------------------------------
package ofs_pkg;

   // Default width of one coordinate on the request beat.
   localparam int DEFAULT_COORD_WIDTH = 32;

   // Result field width and the packed width of the response beat.
   localparam int OUT_W  = 48;
   localparam int LANES  = 4;
   localparam int RSP_DW = LANES * OUT_W;

   // Configuration port.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Pipeline depths: front end, divider (two set-up stages and one stage per
   // quotient bit) and the whole datapath ahead of the output register.
   localparam int FRONT_STAGES = 10;
   localparam int DIV_ITER     = 49;
   localparam int DIV_FRAC     = 23;
   localparam int DIV_LOW_W    = DIV_ITER - DIV_FRAC;
   localparam int DIV_STAGES   = DIV_ITER + 2;
   localparam int PIPE_STAGES  = FRONT_STAGES + DIV_STAGES;

   // Floor division by three: bias to a non-negative value, multiply by the
   // rounded-up reciprocal scaled by 2^36, then remove the scaled bias.
   localparam logic signed [63:0] DIV3_BIAS   = 64'sd25769803776;
   localparam logic        [34:0] RECIP_THREE = 35'd22906492246;
   localparam logic signed [34:0] P0_BIAS     = 35'sd8589934592;

   // One plus delta in Q2.30.
   localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

   // Saturation limits.
   localparam logic [OUT_W-1:0] OUT_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [OUT_W-1:0] OUT_MIN = 48'h8000_0000_0000;
   localparam logic [DIV_ITER-1:0] POS_LIM = 49'h0_7FFF_FFFF_FFFF;
   localparam logic [DIV_ITER-1:0] NEG_LIM = 49'h0_8000_0000_0000;

   // Register indexes (byte address divided by four).
   typedef enum logic [2:0] {
      REG_OCTUPOLE  = 3'd0,
      REG_QUAD      = 3'd1,
      REG_COS_TILT  = 3'd2,
      REG_SIN_TILT  = 3'd3,
      REG_STEER_H   = 3'd4,
      REG_STEER_V   = 3'd5
   } csr_reg_type;

   // Reset value of the cosine register (1.0 in Q1.30).
   localparam logic signed [31:0] COS_RESET = 32'sd1073741824;

   // Per-beat flags carried through the divider pipeline.
   typedef struct packed {
      logic             bad;
      logic [LANES-1:0] ovf;
      logic [LANES-1:0] neg;
   } div_flag_type;

endpackage

// File: design/ofs_div_pipe.sv
// ----------------------------------------------------------------------------
// Octupole field strength divider pipeline
// Four lanes of restoring division of a Q40 numerator by a shared positive
// Q30 divisor, one quotient bit per stage, giving floor(|num|*2^23/den).
// ----------------------------------------------------------------------------
module ofs_div_pipe (
   input  logic                      clock,
   input  logic                      advance,
   input  logic signed [63:0]        num_in [ofs_pkg::LANES],
   input  logic        [31:0]        den_in,
   input  logic                      bad_in,
   output logic [ofs_pkg::DIV_ITER-1:0] quo_out [ofs_pkg::LANES],
   output ofs_pkg::div_flag_type     flag_out
);

   localparam int LANES = ofs_pkg::LANES;
   localparam int ITER  = ofs_pkg::DIV_ITER;
   localparam int LOW_W = ofs_pkg::DIV_LOW_W;

   // First stage: magnitudes and signs.
   logic [63:0]       mag_ff [LANES];
   logic [LANES-1:0]  sign_ff;
   logic [31:0]       den_a_ff;
   logic              bad_a_ff;

   // Iteration stages, index 0 is the set-up stage.
   logic [31:0]           rem_ff  [ITER+1][LANES];
   logic [ITER-1:0]       quo_ff  [ITER+1][LANES];
   logic [LOW_W-1:0]      low_ff  [ITER+1][LANES];
   logic [31:0]           den_ff  [ITER+1];
   ofs_pkg::div_flag_type flag_ff [ITER+1];

   // Take the magnitude of each numerator.
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int l = 0; l < LANES; l++) begin
            sign_ff[l] <= num_in[l][63];
            mag_ff[l]  <= num_in[l][63] ? 64'(-num_in[l]) : 64'(num_in[l]);
         end
         den_a_ff <= den_in;
         bad_a_ff <= bad_in;
      end
   end

   // Detect overflow of the quotient and load the initial partial remainder.
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int l = 0; l < LANES; l++) begin
            flag_ff[0].ovf[l] <= (mag_ff[l] >= {6'b0, den_a_ff, 26'b0});
            rem_ff[0][l]      <= mag_ff[l][57:26];
            low_ff[0][l]      <= mag_ff[l][LOW_W-1:0];
            quo_ff[0][l]      <= '0;
         end
         flag_ff[0].neg <= sign_ff;
         flag_ff[0].bad <= bad_a_ff;
         den_ff[0]      <= den_a_ff;
      end
   end

   // One quotient bit per stage.
   for (genvar j = 0; j < ITER; j++) begin : g_iter
      localparam int BI = ITER - 1 - j;

      always_ff @(posedge clock) begin
         if (advance) begin
            den_ff[j+1]  <= den_ff[j];
            flag_ff[j+1] <= flag_ff[j];
         end
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic        shift_in;
         logic [32:0] part;
         logic [33:0] diff;

         // Dividend bits below the fraction point are zero.
         if (BI >= ofs_pkg::DIV_FRAC) begin : g_data
            assign shift_in = low_ff[j][l][BI-ofs_pkg::DIV_FRAC];
         end else begin : g_zero
            assign shift_in = 1'b0;
         end

         assign part = {rem_ff[j][l], shift_in};
         assign diff = {1'b0, part} - {2'b0, den_ff[j]};

         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[j+1][l] <= diff[33] ? part[31:0] : diff[31:0];
               quo_ff[j+1][l] <= {quo_ff[j][l][ITER-2:0], ~diff[33]};
               low_ff[j+1][l] <= low_ff[j][l];
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         quo_out[l] = quo_ff[ITER][l];
      end
   end

   assign flag_out = flag_ff[ITER];

endmodule

// File: design/octupole_field_strength_unit.sv
// ----------------------------------------------------------------------------
// Octupole field strength unit
// Dipole and quadrupole strengths of a combined octupole, tilted quadrupole
// and steering magnet at one particle, scaled by 1/(1+delta).
// ----------------------------------------------------------------------------
// The unit takes one particle beat per clock cycle while its spare output
// stage is free, and returns one result beat per particle, in order. The rate
// is set by the fully pipelined datapath: ten front-end stages of multipliers
// and adders, then a 51-stage divider that produces one quotient bit per
// stage for all four results in parallel, then the output register. A spare
// output stage lets one more result leave the pipeline while a result waits
// on the output, so the request side keeps flowing until a result has to
// wait in the spare stage; after that the whole pipeline holds. Registers
// are to be written over the APB port only while no beat is in flight; the
// unit itself does not enforce this.
// ----------------------------------------------------------------------------
module octupole_field_strength_unit #(
   parameter int COORD_WIDTH = ofs_pkg::DEFAULT_COORD_WIDTH
) (
   input  logic clock,
   input  logic reset,

   // Request: pos_x, pos_y, momentum_dev (low to high), zero padded.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]   req_tdata,

   // Response: dipole_re, dipole_im, quad_re, quad_im (low to high).
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ofs_pkg::RSP_DW-1:0]           rsp_tdata,
   // Response user: bad_momentum.
   output logic                                 rsp_tuser,

   // Configuration port.
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ofs_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [ofs_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [ofs_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);

   localparam int LANES = ofs_pkg::LANES;
   localparam int OUT_W = ofs_pkg::OUT_W;
   localparam int FRONT = ofs_pkg::FRONT_STAGES;
   localparam int PIPE  = ofs_pkg::PIPE_STAGES;
   localparam int ITER  = ofs_pkg::DIV_ITER;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic signed [31:0] octupole_ff, quad_ff, cos_ff, sin_ff, steer_h_ff, steer_v_ff;
   logic               csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         octupole_ff <= '0;
         quad_ff     <= '0;
         cos_ff      <= ofs_pkg::COS_RESET;
         sin_ff      <= '0;
         steer_h_ff  <= '0;
         steer_v_ff  <= '0;
      end else if (csr_write) begin
         case (ofs_pkg::csr_reg_type'(csr_paddr[4:2]))
            ofs_pkg::REG_OCTUPOLE: octupole_ff <= csr_pwdata;
            ofs_pkg::REG_QUAD:     quad_ff     <= csr_pwdata;
            ofs_pkg::REG_COS_TILT: cos_ff      <= csr_pwdata;
            ofs_pkg::REG_SIN_TILT: sin_ff      <= csr_pwdata;
            ofs_pkg::REG_STEER_H:  steer_h_ff  <= csr_pwdata;
            ofs_pkg::REG_STEER_V:  steer_v_ff  <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // Register reads.
   always_comb begin
      case (ofs_pkg::csr_reg_type'(csr_paddr[4:2]))
         ofs_pkg::REG_OCTUPOLE: csr_prdata = octupole_ff;
         ofs_pkg::REG_QUAD:     csr_prdata = quad_ff;
         ofs_pkg::REG_COS_TILT: csr_prdata = cos_ff;
         ofs_pkg::REG_SIN_TILT: csr_prdata = sin_ff;
         ofs_pkg::REG_STEER_H:  csr_prdata = steer_h_ff;
         ofs_pkg::REG_STEER_V:  csr_prdata = steer_v_ff;
         default:               csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Flow control
   // ---------------------------------------------------------------------
   logic            advance;
   logic [PIPE-1:0] vld_ff;
   logic            spare_vld_ff;

   // The pipeline moves whenever the spare output stage is free.
   assign advance    = ~spare_vld_ff;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[PIPE-2:0], req_tvalid};
      end
   end

   // ---------------------------------------------------------------------
   // Coordinate alignment to Q1.30
   // ---------------------------------------------------------------------
   logic signed [COORD_WIDTH-1:0] raw_x, raw_y, raw_d;
   logic signed [31:0]            x_al, y_al, d_al;

   assign raw_x = req_tdata[COORD_WIDTH-1:0];
   assign raw_y = req_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
   assign raw_d = req_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];

   if (COORD_WIDTH > 32) begin : g_narrow
      assign x_al = 32'(raw_x >>> (COORD_WIDTH - 32));
      assign y_al = 32'(raw_y >>> (COORD_WIDTH - 32));
      assign d_al = 32'(raw_d >>> (COORD_WIDTH - 32));
   end else if (COORD_WIDTH < 32) begin : g_widen
      assign x_al = {raw_x, {(32-COORD_WIDTH){1'b0}}};
      assign y_al = {raw_y, {(32-COORD_WIDTH){1'b0}}};
      assign d_al = {raw_d, {(32-COORD_WIDTH){1'b0}}};
   end else begin : g_same
      assign x_al = raw_x;
      assign y_al = raw_y;
      assign d_al = raw_d;
   end

   // ---------------------------------------------------------------------
   // Front-end datapath
   // ---------------------------------------------------------------------
   logic signed [33:0] den_in;
   logic               bad_in;
   logic        [31:0] den_ff [FRONT];
   logic               bad_ff [FRONT];

   logic signed [31:0] x0_ff, y0_ff, x1_ff, y1_ff, x2_ff, y2_ff;
   logic signed [63:0] xsq1_ff, ysq1_ff, xy1_ff, rr1_ff, ri1_ff;
   logic signed [29:0] xx2_ff, yy2_ff, x28_2_ff, y28_2_ff;
   logic signed [30:0] qre2_ff;
   logic signed [31:0] qim2_ff;
   logic signed [33:0] rr16_2_ff, ri16_2_ff;
   logic signed [57:0] rrq2_ff, riq2_ff, rrq3_ff, riq3_ff;
   logic signed [61:0] xxx3_ff, xyy3_ff, yyy3_ff, yxx3_ff;
   logic signed [63:0] k3re3_ff, k3im3_ff, pa3_ff, pb3_ff, pc3_ff, pd3_ff;
   logic signed [63:0] cx4_ff, cy4_ff;
   logic signed [63:0] n1re_ff [4:9];
   logic signed [63:0] n1im_ff [4:9];
   logic signed [63:0] dre_ff  [4:8];
   logic signed [63:0] dim_ff  [4:8];
   logic        [34:0] ux5_ff, uy5_ff;
   logic        [69:0] mx6_ff, my6_ff;
   logic signed [33:0] px7_ff, py7_ff;
   logic signed [63:0] k3px8_ff, k3py8_ff;
   logic signed [63:0] n0re9_ff, n0im9_ff;

   // One plus delta, and the non-positive momentum flag.
   assign den_in = ofs_pkg::ONE_Q30 + 34'(d_al);
   assign bad_in = den_in[33] || (den_in == '0);

   // Divisor and flag travel alongside the front end.
   always_ff @(posedge clock) begin
      if (advance) begin
         den_ff[0] <= den_in[31:0];
         bad_ff[0] <= bad_in;
         for (int k = 1; k < FRONT; k++) begin
            den_ff[k] <= den_ff[k-1];
            bad_ff[k] <= bad_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         // Stage 0: aligned coordinates.
         x0_ff <= x_al;
         y0_ff <= y_al;

         // Stage 1: squares, cross product and rotated quadrupole strength.
         x1_ff   <= x0_ff;
         y1_ff   <= y0_ff;
         xsq1_ff <= x0_ff * x0_ff;
         ysq1_ff <= y0_ff * y0_ff;
         xy1_ff  <= x0_ff * y0_ff;
         rr1_ff  <= quad_ff * cos_ff;
         ri1_ff  <= quad_ff * sin_ff;

         // Stage 2: rescale the products.
         x2_ff     <= x1_ff;
         y2_ff     <= y1_ff;
         xx2_ff    <= 30'(xsq1_ff >>> 34);
         yy2_ff    <= 30'(ysq1_ff >>> 34);
         qre2_ff   <= 31'((xsq1_ff - ysq1_ff) >>> 33);
         qim2_ff   <= 32'((-xy1_ff) >>> 32);
         rr16_2_ff <= 34'(rr1_ff >>> 30);
         ri16_2_ff <= 34'(ri1_ff >>> 30);
         rrq2_ff   <= 58'(rr1_ff >>> 6);
         riq2_ff   <= 58'(ri1_ff >>> 6);
         x28_2_ff  <= 30'(x1_ff >>> 2);
         y28_2_ff  <= 30'(y1_ff >>> 2);

         // Stage 3: cubic partial products and strength products.
         xxx3_ff  <= x2_ff * xx2_ff;
         xyy3_ff  <= x2_ff * yy2_ff;
         yyy3_ff  <= y2_ff * yy2_ff;
         yxx3_ff  <= y2_ff * xx2_ff;
         k3re3_ff <= octupole_ff * qre2_ff;
         k3im3_ff <= octupole_ff * qim2_ff;
         pa3_ff   <= rr16_2_ff * x28_2_ff;
         pb3_ff   <= ri16_2_ff * y28_2_ff;
         pc3_ff   <= ri16_2_ff * x28_2_ff;
         pd3_ff   <= rr16_2_ff * y28_2_ff;
         rrq3_ff  <= rrq2_ff;
         riq3_ff  <= riq2_ff;

         // Stage 4: cubic numerators, quadrupole numerators, dipole partial sums.
         cx4_ff     <= xxx3_ff - 3 * xyy3_ff;
         cy4_ff     <= yyy3_ff - 3 * yxx3_ff;
         n1re_ff[4] <= (k3re3_ff >>> 4) + rrq3_ff;
         n1im_ff[4] <= (k3im3_ff >>> 4) + riq3_ff;
         dre_ff[4]  <= (pa3_ff >>> 4) + (pb3_ff >>> 4) + (64'(steer_h_ff) <<< 24);
         dim_ff[4]  <= (pc3_ff >>> 4) - (pd3_ff >>> 4) + (64'(steer_v_ff) <<< 24);

         // Stage 5: scale by 2^-29 and bias for the division by three.
         ux5_ff <= 35'((cx4_ff >>> 29) + ofs_pkg::DIV3_BIAS);
         uy5_ff <= 35'((cy4_ff >>> 29) + ofs_pkg::DIV3_BIAS);

         // Stage 6: multiply by the reciprocal of three.
         mx6_ff <= ux5_ff * ofs_pkg::RECIP_THREE;
         my6_ff <= uy5_ff * ofs_pkg::RECIP_THREE;

         // Stage 7: remove the bias to get the Q28 polynomial terms.
         px7_ff <= 34'($signed({1'b0, mx6_ff[69:36]}) - ofs_pkg::P0_BIAS);
         py7_ff <= 34'($signed({1'b0, my6_ff[69:36]}) - ofs_pkg::P0_BIAS);

         // Stage 8: octupole cubic products.
         k3px8_ff <= octupole_ff * px7_ff;
         k3py8_ff <= octupole_ff * py7_ff;

         // Stage 9: dipole numerators.
         n0re9_ff <= (k3px8_ff >>> 4) + dre_ff[8];
         n0im9_ff <= (k3py8_ff >>> 4) + dim_ff[8];

         // Carried terms.
         for (int k = 5; k <= 9; k++) begin
            n1re_ff[k] <= n1re_ff[k-1];
            n1im_ff[k] <= n1im_ff[k-1];
         end
         for (int k = 5; k <= 8; k++) begin
            dre_ff[k] <= dre_ff[k-1];
            dim_ff[k] <= dim_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Division by one plus delta
   // ---------------------------------------------------------------------
   logic signed [63:0]    num [LANES];
   logic [ITER-1:0]       quo [LANES];
   ofs_pkg::div_flag_type flags;

   always_comb begin
      num[0] = n0re9_ff;
      num[1] = n0im9_ff;
      num[2] = n1re_ff[9];
      num[3] = n1im_ff[9];
   end

   ofs_div_pipe u_div (
      .clock    (clock),
      .advance  (advance),
      .num_in   (num),
      .den_in   (den_ff[FRONT-1]),
      .bad_in   (bad_ff[FRONT-1]),
      .quo_out  (quo),
      .flag_out (flags)
   );

   // ---------------------------------------------------------------------
   // Rounding, saturation and result packing
   // ---------------------------------------------------------------------
   logic [ofs_pkg::RSP_DW-1:0] fin_data;
   logic [ITER-1:0]            q_rnd [LANES];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         // Round half up on the magnitude, which is half away from zero.
         q_rnd[l] = ITER'(({1'b0, quo[l]} + (ITER+1)'(1)) >> 1);
         if (flags.bad) begin
            fin_data[l*OUT_W +: OUT_W] = '0;
         end else if (flags.ovf[l]) begin
            fin_data[l*OUT_W +: OUT_W] = flags.neg[l] ? ofs_pkg::OUT_MIN : ofs_pkg::OUT_MAX;
         end else if (flags.neg[l]) begin
            fin_data[l*OUT_W +: OUT_W] = (q_rnd[l] > ofs_pkg::NEG_LIM) ?
                                         ofs_pkg::OUT_MIN : OUT_W'(~q_rnd[l] + 1'b1);
         end else begin
            fin_data[l*OUT_W +: OUT_W] = (q_rnd[l] > ofs_pkg::POS_LIM) ?
                                         ofs_pkg::OUT_MAX : q_rnd[l][OUT_W-1:0];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Output register with a spare stage
   // ---------------------------------------------------------------------
   logic                       fin_vld;
   logic                       rsp_vld_ff;
   logic [ofs_pkg::RSP_DW-1:0] rsp_data_ff, spare_data_ff;
   logic                       rsp_bad_ff, spare_bad_ff;

   assign fin_vld = vld_ff[PIPE-1] && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff   <= 1'b0;
         spare_vld_ff <= 1'b0;
      end else if (!rsp_vld_ff || rsp_tready) begin
         rsp_vld_ff   <= spare_vld_ff || fin_vld;
         spare_vld_ff <= 1'b0;
      end else if (fin_vld) begin
         spare_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_vld_ff || rsp_tready) begin
         rsp_data_ff <= spare_vld_ff ? spare_data_ff : fin_data;
         rsp_bad_ff  <= spare_vld_ff ? spare_bad_ff  : flags.bad;
      end else if (fin_vld) begin
         spare_data_ff <= fin_data;
         spare_bad_ff  <= flags.bad;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_bad_ff;

endmodule
